/* hdl/rpf_pkg.sv */
// Package for the radio packet framer: result type, sequencing phases,
// framing constants and the byte-wide reflected CRC16 update.
// No dependencies.
`default_nettype none

package rpf_pkg;

  // Framing constants
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [7:0]  HDR_MASK  = 8'h1F;
  localparam logic [7:0]  PAD_BYTE  = 8'hAA;
  localparam logic [3:0]  PAD_LAST  = 4'd11;

  // Position within the run of results that one request causes
  typedef enum logic [2:0] {
    PH_START,
    PH_HDR,
    PH_LEN,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_PAD
  } phase_t;

  // One result going towards the transmit FIFO
  typedef struct packed {
    logic [7:0] fifo_byte;
    logic       last_of_run;
    logic       end_of_packet;
  } result_t;

  // Reflected CRC16 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/radio_packet_framer_crc16_top.sv */
// Top level of the radio packet framer with CRC16.
// Depends on rpf_pkg and rpf_out_reg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one payload byte per request;
//   group, node and length are read only on the first request of a packet.
//   Output channel (out_valid/out_ready) delivers bytes for the radio
//   transmit FIFO with last_of_run and end_of_packet flags.
//   A request is held in an item register and its results are sequenced one
//   per cycle into the output register: 1 result for a mid-packet byte,
//   3 for the first byte of a packet, plus 14 (CRC low, CRC high, twelve
//   pad bytes) on the last byte. A request therefore occupies the item
//   register until its last result is loaded; mid-packet bytes stream at
//   one per cycle. The first result passes through the item register and
//   then the output register before the receiver can take it.
//   The next request is accepted in the cycle its predecessor's last result
//   is loaded. When the receiver stalls, the output register holds its
//   result and sequencing pauses; the item register then fills and
//   in_ready falls.
//   Reset (rst, synchronous) empties both registers, sets the CRC to all
//   ones and closes any open packet.
`default_nettype none

module radio_packet_framer_crc16_top
  import rpf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] group,
  input  wire logic [7:0] node,
  input  wire logic [7:0] length,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      fifo_byte,
  output logic            last_of_run,
  output logic            end_of_packet
);

  // Item register
  logic        item_valid;
  logic [15:0] grp_crc;
  logic [7:0]  hdr;
  logic [7:0]  len;
  logic [7:0]  dat;

  // Packet state
  phase_t      phase, phase_next;
  logic [3:0]  pad_cnt, pad_cnt_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  remaining, remaining_next;

  phase_t      cur_phase;
  logic        cur_last;
  logic [7:0]  rem_dec;
  result_t     res;
  result_t     res_q;
  logic        can_load;
  logic        load;
  logic        in_acc;

  assign load     = item_valid && can_load;
  assign in_ready = !item_valid || (load && cur_last);
  assign in_acc   = in_valid && in_ready;

  // Opening or continuing a packet is decided once the previous run is done
  assign cur_phase = (phase == PH_START) ? ((remaining == 8'd0) ? PH_HDR : PH_DATA) : phase;
  assign rem_dec   = remaining - 8'd1;

  // Result selection and next state
  always_comb begin
    res            = '0;
    cur_last       = 1'b0;
    phase_next     = phase;
    pad_cnt_next   = pad_cnt;
    crc_next       = crc;
    remaining_next = remaining;
    unique case (cur_phase)
      PH_HDR: begin
        res.fifo_byte = hdr;
        crc_next      = crc_byte(grp_crc, hdr);
        phase_next    = PH_LEN;
      end
      PH_LEN: begin
        res.fifo_byte  = len;
        crc_next       = crc_byte(crc, len);
        remaining_next = len;
        phase_next     = PH_DATA;
      end
      PH_DATA: begin
        res.fifo_byte  = dat;
        crc_next       = crc_byte(crc, dat);
        remaining_next = rem_dec;
        if (rem_dec == 8'd0) begin
          phase_next = PH_CRC_LO;
        end else begin
          cur_last   = 1'b1;
          phase_next = PH_START;
        end
      end
      PH_CRC_LO: begin
        res.fifo_byte = crc[7:0];
        phase_next    = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        res.fifo_byte = crc[15:8];
        pad_cnt_next  = 4'd0;
        phase_next    = PH_PAD;
      end
      PH_PAD: begin
        res.fifo_byte = PAD_BYTE;
        if (pad_cnt == PAD_LAST) begin
          res.end_of_packet = 1'b1;
          cur_last          = 1'b1;
          crc_next          = CRC_INIT;
          phase_next        = PH_START;
        end else begin
          pad_cnt_next = pad_cnt + 4'd1;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
    res.last_of_run = cur_last;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      phase      <= PH_START;
      pad_cnt    <= 4'd0;
      crc        <= CRC_INIT;
      remaining  <= 8'd0;
    end else begin
      if (in_acc) begin
        item_valid <= 1'b1;
      end else if (load && cur_last) begin
        item_valid <= 1'b0;
      end
      if (load) begin
        pad_cnt   <= pad_cnt_next;
        crc       <= crc_next;
        remaining <= remaining_next;
      end
      if (in_acc) begin
        phase <= PH_START;
      end else if (load) begin
        phase <= phase_next;
      end
    end
  end

  // Item payload; group is folded into the CRC on capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      grp_crc <= crc_byte(CRC_INIT, group);
      hdr     <= node & HDR_MASK;
      len     <= (length == 8'd0) ? 8'd1 : length;
      dat     <= data_byte;
    end
  end

  rpf_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .din       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (res_q)
  );

  assign fifo_byte     = res_q.fifo_byte;
  assign last_of_run   = res_q.last_of_run;
  assign end_of_packet = res_q.end_of_packet;

  // Checks
  a_eop_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_packet |-> last_of_run)
    else $error("end_of_packet without last_of_run");

  a_pad_range: assert property (@(posedge clk) disable iff (rst)
    item_valid && phase == PH_PAD |-> pad_cnt <= PAD_LAST)
    else $error("pad counter out of range");

  a_trailer_closed: assert property (@(posedge clk) disable iff (rst)
    item_valid && (phase == PH_CRC_LO || phase == PH_CRC_HI || phase == PH_PAD)
    |-> remaining == 8'd0)
    else $error("trailer while packet bytes still owed");

  a_packet_reset: assert property (@(posedge clk) disable iff (rst)
    load && cur_phase == PH_PAD && pad_cnt == PAD_LAST
    |=> crc == CRC_INIT && remaining == 8'd0)
    else $error("CRC not restarted after packet end");

endmodule

`default_nettype wire

/* hdl/rpf_out_reg.sv */
// Output register of the packet framer: holds one result until the
// receiver takes it. Depends on rpf_pkg for the result type.
`default_nettype none

module rpf_out_reg
  import rpf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t din,
  output logic         can_load,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      dout
);

  // Free when empty or when the held result leaves this cycle
  assign can_load = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

/* verif/rpf_frame_checker.sv */
// Checker for the radio packet framer: watches the request and FIFO byte
// channels, predicts each byte from its own framing and CRC16 model, compares.
// Depends on rpf_pkg for the result type and framing constants.
module rpf_frame_checker
  import rpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] group,
  input  logic [7:0] node,
  input  logic [7:0] length,
  input  logic [7:0] data_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] fifo_byte,
  input  logic       last_of_run,
  input  logic       end_of_packet,
  output int         fail_count,
  output int         pending,
  output int         requests_seen,
  output int         bytes_seen,
  output int         packets_closed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted framer state
  logic [15:0] crc_run = CRC_INIT;
  logic [7:0]  owed_bytes = 8'd0;
  result_t     fifo_bytes_due[$];

  // Reflected CRC16, one input bit at a time, LSB first
  function automatic logic [15:0] fold_crc(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = {1'b0, r[15:1]};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Queue the FIFO bytes that one request should produce
  task automatic frame_request(input logic [7:0] g, input logic [7:0] n,
                               input logic [7:0] l, input logic [7:0] d);
    logic [7:0] hdr;
    logic [7:0] len_eff;
    if (owed_bytes == 8'd0) begin
      // first request of a packet: header and length go out ahead of data
      hdr     = n & HDR_MASK;
      len_eff = (l == 8'd0) ? 8'd1 : l;
      crc_run = fold_crc(fold_crc(fold_crc(CRC_INIT, g), hdr), len_eff);
      fifo_bytes_due.push_back('{hdr, 1'b0, 1'b0});
      fifo_bytes_due.push_back('{len_eff, 1'b0, 1'b0});
      owed_bytes = len_eff;
    end
    crc_run    = fold_crc(crc_run, d);
    owed_bytes = owed_bytes - 8'd1;
    fifo_bytes_due.push_back('{d, owed_bytes != 8'd0, 1'b0});
    if (owed_bytes == 8'd0) begin
      // packet closes: CRC low, CRC high, then the pad run
      fifo_bytes_due.push_back('{crc_run[7:0], 1'b0, 1'b0});
      fifo_bytes_due.push_back('{crc_run[15:8], 1'b0, 1'b0});
      for (int k = 0; k <= PAD_LAST; k++) begin
        fifo_bytes_due.push_back('{PAD_BYTE, k == PAD_LAST, k == PAD_LAST});
      end
      crc_run = CRC_INIT;
    end
  endtask

  // Sample both channels at the clock edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      crc_run    = CRC_INIT;
      owed_bytes = 8'd0;
      fifo_bytes_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        requests_seen++;
        frame_request(group, node, length, data_byte);
      end
      if (out_valid && out_ready) begin
        bytes_seen++;
        if (fifo_bytes_due.size() == 0) begin
          $error("unexpected FIFO byte %02h with nothing outstanding", fifo_byte);
          fail_count++;
        end else begin
          want = fifo_bytes_due.pop_front();
          if (fifo_byte !== want.fifo_byte) begin
            $error("fifo_byte: expected %02h, got %02h", want.fifo_byte, fifo_byte);
            fail_count++;
          end
          if (last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, last_of_run);
            fail_count++;
          end
          if (end_of_packet !== want.end_of_packet) begin
            $error("end_of_packet: expected %0b, got %0b", want.end_of_packet,
                   end_of_packet);
            fail_count++;
          end
          if (want.end_of_packet) begin
            packets_closed++;
          end
        end
      end
    end
    pending = fifo_bytes_due.size();
  end

endmodule

/* verif/tb_radio_packet_framer_crc16_top.sv */
// Testbench top for the radio packet framer: clock, reset, request stimulus,
// FIFO-side back-pressure and the final verdict.
// Depends on rpf_pkg, radio_packet_framer_crc16_top and rpf_frame_checker.
module tb_radio_packet_framer_crc16_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REQUEST_TARGET = 420;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] group = 8'h00;
  logic [7:0] node = 8'h00;
  logic [7:0] length = 8'h00;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] fifo_byte;
  logic       last_of_run;
  logic       end_of_packet;

  // idling on both sides is enabled per packet
  logic       idle_on = 1'b0;
  int         rx_hold = 0;
  int         requests_sent = 0;
  bit         long_packet_done = 0;

  int fail_count;
  int pending;
  int requests_seen;
  int bytes_seen;
  int packets_closed;

  always #5 clk = ~clk;

  radio_packet_framer_crc16_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .group(group), .node(node), .length(length), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .fifo_byte(fifo_byte), .last_of_run(last_of_run), .end_of_packet(end_of_packet)
  );

  rpf_frame_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .group(group), .node(node), .length(length), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .fifo_byte(fifo_byte), .last_of_run(last_of_run), .end_of_packet(end_of_packet),
    .fail_count(fail_count), .pending(pending), .requests_seen(requests_seen),
    .bytes_seen(bytes_seen), .packets_closed(packets_closed)
  );

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // FIFO side back-pressure
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_hold   <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one request and hold it until taken, then maybe idle
  task automatic send_request(input logic [7:0] g, input logic [7:0] n,
                              input logic [7:0] l, input logic [7:0] d);
    int gap;
    group     <= g;
    node      <= n;
    length    <= l;
    data_byte <= d;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid  <= 1'b0;
      group     <= 8'($urandom);
      node      <= 8'($urandom);
      length    <= 8'($urandom);
      data_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Whole packet: header on the first request, junk header fields afterwards
  task automatic send_packet(input logic [7:0] len);
    int count;
    count = (len == 8'd0) ? 1 : int'(len);
    send_request(8'($urandom), 8'($urandom), len, 8'($urandom));
    for (int i = 1; i < count; i++) begin
      send_request(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Stimulus
  initial begin
    logic [7:0] len;
    int         r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: shortest packet with the node's upper bits set
    send_request(8'h00, 8'hFF, 8'd1, 8'h00);
    // zero length is framed as length one
    send_request(8'hFF, 8'hE0, 8'd0, 8'hFF);
    // header fields on later requests must be ignored
    send_request(8'hA5, 8'h1F, 8'd3, 8'h55);
    send_request(8'hFF, 8'hFF, 8'hFF, 8'hAA);
    send_request(8'h00, 8'h00, 8'h00, 8'h80);
    send_request(8'h5A, 8'h15, 8'd2, 8'h01);
    send_request(8'h00, 8'h00, 8'h00, 8'hFE);
    // more directed packets, now with idling on both sides
    idle_on <= 1'b1;
    send_request(8'h3C, 8'h0A, 8'd1, 8'h7F);
    send_request(8'hC3, 8'hEA, 8'd2, 8'h33);
    send_request(8'h12, 8'h34, 8'h56, 8'hCC);

    // random packets, one of the longest length, mostly short ones
    while (requests_sent < REQUEST_TARGET) begin
      idle_on <= ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 99);
      if (!long_packet_done && requests_sent >= 60) begin
        len = 8'd255;
        long_packet_done = 1;
      end else if (r < 5) begin
        len = 8'd0;
      end else if (r < 85) begin
        len = 8'($urandom_range(1, 6));
      end else begin
        len = 8'($urandom_range(7, 40));
      end
      send_packet(len);
    end
    in_valid <= 1'b0;
    idle_on  <= 1'b0;

    // let the checker book the last request, drain, then watch for stray bytes
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d requests over %0d packets; checked %0d FIFO bytes.",
             requests_seen, packets_closed, bytes_seen);
    $display("Covered zero and maximum lengths, ignored mid-packet headers, stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $error("timeout with %0d FIFO bytes outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
hdl/rpf_pkg.sv
hdl/rpf_out_reg.sv
hdl/radio_packet_framer_crc16_top.sv
verif/rpf_frame_checker.sv
verif/tb_radio_packet_framer_crc16_top.sv
